FILE: design/rws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rws_pkg
// Shared constants, codes and types of the roulette-wheel selection block.
// ----------------------------------------------------------------------------
package rws_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_POPULATION_DEF = 256;
    localparam int FITNESS_BITS_DEF   = 32;
    localparam int RANDOM_BITS_DEF    = 16;

    // fixed field widths
    localparam int CFG_W    = 9;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] CFG_POP_RESET = 9'd16;

    // action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SELECT = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FALLBACK = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BEYOND   = 2'd2;

    // completion report of the selection unit
    typedef struct packed {
        logic done;
        logic fallback;
    } t_sel_status;

endpackage

`default_nettype wire

FILE: design/rws_select_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rws_select_unit
// Selection sequencer: one shared add/sub unit forms the span, the scaled
// threshold (shift-add multiply) and the running sum of the table walk.
// ----------------------------------------------------------------------------
module rws_select_unit #(
    parameter int MAX_POPULATION = rws_pkg::MAX_POPULATION_DEF,
    parameter int FITNESS_BITS   = rws_pkg::FITNESS_BITS_DEF,
    parameter int RANDOM_BITS    = rws_pkg::RANDOM_BITS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_start,
    input  wire logic [RANDOM_BITS-1:0]                      i_random,
    input  wire logic [$clog2(MAX_POPULATION+1)-1:0]         i_pop,
    input  wire logic signed [FITNESS_BITS+$clog2(MAX_POPULATION):0] i_total,
    input  wire logic signed [FITNESS_BITS-1:0]              i_minimum,
    input  wire logic signed [FITNESS_BITS-1:0]              i_rd_data,
    output logic                                             o_rd_en,
    output logic [$clog2(MAX_POPULATION)-1:0]                o_rd_addr,
    output logic [$clog2(MAX_POPULATION+1)-1:0]              o_index,
    output rws_pkg::t_sel_status                             o_status
);

    localparam int IDX_W   = $clog2(MAX_POPULATION);
    localparam int POP_W   = $clog2(MAX_POPULATION + 1);
    localparam int SPAN_W  = FITNESS_BITS + IDX_W + 2;
    localparam int PROD_W  = SPAN_W + RANDOM_BITS;
    localparam int MPL_W   = (POP_W > RANDOM_BITS) ? POP_W : RANDOM_BITS;
    localparam int CNT_W   = $clog2(MPL_W + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SPAN = 4'b0010,
        S_MUL  = 4'b0100,
        S_WALK = 4'b1000
    } t_sel_state;

    t_sel_state                  r_state;
    logic signed [PROD_W-1:0]    r_acc;
    logic signed [PROD_W-1:0]    r_mcand;
    logic [MPL_W-1:0]            r_mplier;
    logic [CNT_W-1:0]            r_cnt;
    logic [RANDOM_BITS-1:0]      r_random;
    logic signed [SPAN_W-1:0]    r_k;
    logic [POP_W-1:0]            r_raddr;
    logic                        r_v1;
    logic [POP_W-1:0]            r_i1;
    logic signed [FITNESS_BITS:0] r_diff;
    logic                        r_v2;
    logic [POP_W-1:0]            r_i2;
    logic [POP_W-1:0]            r_index;
    logic                        r_done;
    logic                        r_fallback;

    logic signed [PROD_W-1:0]    operand;
    logic                        sub;
    logic signed [PROD_W-1:0]    sum;
    logic signed [PROD_W-1:0]    k_ext;
    logic                        hit;
    logic                        last;

    // shared add/sub unit
    always_comb begin
        operand = '0;
        sub     = 1'b0;
        case (r_state)
            S_SPAN: begin
                sub = 1'b1;
                if (r_mplier[0]) begin
                    operand = r_mcand;
                end
            end
            S_MUL: begin
                if (r_mplier[0]) begin
                    operand = r_mcand;
                end
            end
            S_WALK: begin
                operand = PROD_W'(r_diff);
            end
            default: begin
                operand = '0;
            end
        endcase
        sum = r_acc + (sub ? ~operand : operand) + PROD_W'(sub);
    end

    assign k_ext     = PROD_W'(r_k);
    assign hit       = (k_ext <= sum);
    assign last      = (r_i2 == (i_pop - POP_W'(1)));
    assign o_rd_en   = (r_state == S_WALK) && (r_raddr < i_pop);
    assign o_rd_addr = r_raddr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_done     <= 1'b0;
            r_fallback <= 1'b0;
        end else begin
            r_v1       <= o_rd_en;
            r_v2       <= r_v1;
            r_done     <= 1'b0;
            r_fallback <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_v2 && (hit || last)) begin
                        r_state    <= S_IDLE;
                        r_done     <= 1'b1;
                        r_fallback <= !hit;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i1   <= r_raddr;
        r_i2   <= r_i1;
        r_diff <= (FITNESS_BITS+1)'(i_rd_data) - (FITNESS_BITS+1)'(i_minimum);
        case (r_state)
            S_IDLE: begin
                // span starts from the total, pop * minimum is taken off bit by bit
                r_acc    <= PROD_W'(i_total);
                r_mcand  <= PROD_W'(i_minimum);
                r_mplier <= MPL_W'(i_pop);
                r_cnt    <= CNT_W'(POP_W);
                r_random <= i_random;
            end
            S_SPAN: begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_acc    <= '0;
                    r_mcand  <= sum;
                    r_mplier <= MPL_W'(r_random);
                    r_cnt    <= CNT_W'(RANDOM_BITS);
                end else begin
                    r_acc    <= sum;
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                end
            end
            S_MUL: begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    // arithmetic shift floors toward minus infinity
                    r_k     <= SPAN_W'(sum >>> RANDOM_BITS);
                    r_acc   <= '0;
                    r_raddr <= '0;
                end else begin
                    r_acc    <= sum;
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                end
            end
            S_WALK: begin
                if (o_rd_en) begin
                    r_raddr <= r_raddr + POP_W'(1);
                end
                if (r_v2) begin
                    r_acc   <= sum;
                    r_index <= hit ? r_i2 : '0;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_index           = r_index;
    assign o_status.done     = r_done;
    assign o_status.fallback = r_fallback;

endmodule

`default_nettype wire

FILE: design/roulette_wheel_selection_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roulette_wheel_selection_top
// Fitness-proportionate selection over a loaded table of signed fitness
// values, offset by the population minimum so negative values are handled.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  input     in         i_in_valid / o_in_ready        action, start, fitness, random
//  output    out        o_out_valid / i_out_ready      selected_index, status
//  config    in         i_cfg_wr_en                    i_cfg_wr_data (population size)
//
//  a load is handled in the transfer cycle, which also registers its result
//  a select result is registered when the walk ends (index is 0 for a fallback):
//  span and threshold come from the shared add/sub unit one bit per cycle, then
//  the walk reads one entry per cycle
//  o_in_ready is low during a select and while an untaken result blocks the
//  output register; reset clears control state only, the table is not cleared
// ----------------------------------------------------------------------------
module roulette_wheel_selection_top #(
    parameter int MAX_POPULATION = rws_pkg::MAX_POPULATION_DEF,
    parameter int FITNESS_BITS   = rws_pkg::FITNESS_BITS_DEF,
    parameter int RANDOM_BITS    = rws_pkg::RANDOM_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_action,
    input  wire logic                              i_start_population,
    input  wire logic signed [FITNESS_BITS-1:0]    i_fitness_value,
    input  wire logic [RANDOM_BITS-1:0]            i_random_fraction,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [rws_pkg::INDEX_W-1:0]            o_selected_index,
    output logic [rws_pkg::STATUS_W-1:0]           o_status,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [rws_pkg::CFG_W-1:0]         i_cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_POPULATION);
    localparam int POP_W = $clog2(MAX_POPULATION + 1);
    localparam int TOT_W = FITNESS_BITS + IDX_W + 1;
    localparam int CW    = (rws_pkg::CFG_W > POP_W) ? rws_pkg::CFG_W : POP_W;
    localparam int OW    = (POP_W > rws_pkg::INDEX_W) ? POP_W : rws_pkg::INDEX_W;
    localparam logic signed [FITNESS_BITS-1:0] FIT_MAX = {1'b0, {(FITNESS_BITS-1){1'b1}}};

    typedef enum logic [1:0] {
        TS_IDLE   = 2'b01,
        TS_SELECT = 2'b10
    } t_top_state;

    t_top_state                         r_state;
    logic [rws_pkg::CFG_W-1:0]          r_pop_cfg;
    logic signed [TOT_W-1:0]            r_total;
    logic signed [FITNESS_BITS-1:0]     r_minimum;
    logic [POP_W-1:0]                   r_load_pos;
    logic signed [FITNESS_BITS-1:0]     r_fitness_mem [MAX_POPULATION];
    logic signed [FITNESS_BITS-1:0]     r_rd_data;
    logic                               r_out_valid;
    logic [rws_pkg::INDEX_W-1:0]        r_out_index;
    logic [rws_pkg::STATUS_W-1:0]       r_out_status;

    logic [CW-1:0]                      pop_wide;
    logic [POP_W-1:0]                   pop;
    logic                               accept;
    logic                               load_acc;
    logic                               sel_start;
    logic [POP_W-1:0]                   base_pos;
    logic signed [TOT_W-1:0]            base_total;
    logic signed [FITNESS_BITS-1:0]     base_min;
    logic                               in_range;
    logic signed [TOT_W-1:0]            n_total;
    logic signed [FITNESS_BITS-1:0]     n_minimum;
    logic [OW-1:0]                      load_idx_wide;
    logic [OW-1:0]                      sel_idx_wide;

    logic                               rd_en;
    logic [IDX_W-1:0]                   rd_addr;
    logic [POP_W-1:0]                   sel_index;
    rws_pkg::t_sel_status               sel_status;

    // population size clamped to 1..MAX
    always_comb begin
        pop_wide = CW'(r_pop_cfg);
        if (pop_wide == '0) begin
            pop_wide = CW'(1);
        end else if (pop_wide > CW'(MAX_POPULATION)) begin
            pop_wide = CW'(MAX_POPULATION);
        end
        pop = POP_W'(pop_wide);
    end

    assign o_in_ready = (r_state == TS_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign load_acc   = accept && (i_action == rws_pkg::ACT_LOAD);
    assign sel_start  = accept && (i_action == rws_pkg::ACT_SELECT);

    // load path: a new population restarts from the reset values
    always_comb begin
        base_pos   = i_start_population ? '0 : r_load_pos;
        base_total = i_start_population ? '0 : r_total;
        base_min   = i_start_population ? FIT_MAX : r_minimum;
        in_range   = (base_pos < pop);
        n_total    = base_total + TOT_W'(i_fitness_value);
        n_minimum  = (i_fitness_value < base_min) ? i_fitness_value : base_min;
    end

    assign load_idx_wide = OW'(base_pos);
    assign sel_idx_wide  = OW'(sel_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TS_IDLE;
            r_pop_cfg   <= rws_pkg::CFG_POP_RESET;
            r_total     <= '0;
            r_minimum   <= FIT_MAX;
            r_load_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pop_cfg <= i_cfg_wr_data;
            end
            case (r_state)
                TS_IDLE: begin
                    if (sel_start) begin
                        r_state <= TS_SELECT;
                    end
                end
                TS_SELECT: begin
                    if (sel_status.done) begin
                        r_state <= TS_IDLE;
                    end
                end
                default: begin
                    r_state <= TS_IDLE;
                end
            endcase
            if (load_acc && in_range) begin
                r_total    <= n_total;
                r_minimum  <= n_minimum;
                r_load_pos <= base_pos + POP_W'(1);
            end
            if (load_acc || sel_status.done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            r_out_index  <= load_idx_wide[rws_pkg::INDEX_W-1:0];
            r_out_status <= in_range ? rws_pkg::STATUS_OK : rws_pkg::STATUS_BEYOND;
        end else if (sel_status.done) begin
            r_out_index  <= sel_idx_wide[rws_pkg::INDEX_W-1:0];
            r_out_status <= sel_status.fallback ? rws_pkg::STATUS_FALLBACK
                                                : rws_pkg::STATUS_OK;
        end
    end

    // fitness table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (load_acc && in_range) begin
            r_fitness_mem[base_pos[IDX_W-1:0]] <= i_fitness_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_fitness_mem[rd_addr];
        end
    end

    rws_select_unit #(
        .MAX_POPULATION (MAX_POPULATION),
        .FITNESS_BITS   (FITNESS_BITS),
        .RANDOM_BITS    (RANDOM_BITS)
    ) u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sel_start),
        .i_random  (i_random_fraction),
        .i_pop     (pop),
        .i_total   (r_total),
        .i_minimum (r_minimum),
        .i_rd_data (r_rd_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_index   (sel_index),
        .o_status  (sel_status)
    );

    assign o_out_valid      = r_out_valid;
    assign o_selected_index = r_out_index;
    assign o_status         = r_out_status;

endmodule

`default_nettype wire
